// ===== rtl/smeu_pkg.sv =====
package smeu_pkg;

   localparam int DATA_STACK_DEPTH_DEF = 128;
   localparam int CALL_STACK_DEPTH_DEF = 128;
   localparam int MEMORY_WORDS_DEF     = 512;
   localparam int REGISTER_COUNT_DEF   = 4;

   localparam logic [4:0] OP_PUSH = 5'd0;
   localparam logic [4:0] OP_POP  = 5'd1;
   localparam logic [4:0] OP_JMP  = 5'd2;
   localparam logic [4:0] OP_JB   = 5'd3;
   localparam logic [4:0] OP_JBE  = 5'd4;
   localparam logic [4:0] OP_JA   = 5'd5;
   localparam logic [4:0] OP_JAE  = 5'd6;
   localparam logic [4:0] OP_JE   = 5'd7;
   localparam logic [4:0] OP_JNE  = 5'd8;
   localparam logic [4:0] OP_ADD  = 5'd9;
   localparam logic [4:0] OP_SUB  = 5'd10;
   localparam logic [4:0] OP_MUL  = 5'd11;
   localparam logic [4:0] OP_DIV  = 5'd12;
   localparam logic [4:0] OP_OUT  = 5'd13;
   localparam logic [4:0] OP_IN   = 5'd14;
   localparam logic [4:0] OP_HALT = 5'd15;
   localparam logic [4:0] OP_CALL = 5'd16;
   localparam logic [4:0] OP_RET  = 5'd17;
   localparam logic [4:0] OP_SQRT = 5'd18;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_STACK   = 3'd1;
   localparam logic [2:0] ST_UNKNOWN = 3'd2;
   localparam logic [2:0] ST_HALTED  = 3'd3;
   localparam logic [2:0] ST_DIVZERO = 3'd4;
   localparam logic [2:0] ST_BADADDR = 3'd5;
   localparam logic [2:0] ST_NEGROOT = 3'd6;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RDA,
      S_RDB,
      S_EXEC,
      S_DIV,
      S_SQRT,
      S_FIN
   } state_type;

   typedef struct packed {
      logic [4:0]  op;
      logic        use_const;
      logic        use_reg;
      logic        use_mem;
      logic [31:0] const_value;
      logic [1:0]  reg_select;
      logic [31:0] in_value;
      logic        needs_operand;
   } inst_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_value;
      logic        out_valid;
      logic [15:0] next_ip;
   } rsp_type;

endpackage

// ===== rtl/stack_machine_execute_unit.sv =====
// each instruction steps through the states RDA, RDB, EXEC and FIN, with DIV or SQRT
//   between EXEC and FIN for divide and root; one instruction executes at a time, paced by the
//   stack read sequence (top, then second) and the one-bit-per-cycle divide and root unit
// a two-entry request queue lets requests arrive while an instruction executes
// reset (synchronous): clears stacks depths, registers and pointer, then sweeps data
//   memory to zero, one address after another, with req_tready low meanwhile
module stack_machine_execute_unit
   import smeu_pkg::*;
#(
   parameter int DATA_STACK_DEPTH = DATA_STACK_DEPTH_DEF,
   parameter int CALL_STACK_DEPTH = CALL_STACK_DEPTH_DEF,
   parameter int MEMORY_WORDS     = MEMORY_WORDS_DEF,
   parameter int REGISTER_COUNT   = REGISTER_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op, use_const, use_reg, use_mem, const_value, reg_select, in_value
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_ip, out_valid, out_value, status
   output logic [55:0] rsp_tdata
);

   inst_type head;
   logic     head_valid, pop, clearing;
   rsp_type  rsp;

   smeu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .clearing   (clearing),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   smeu_back #(
      .DATA_STACK_DEPTH (DATA_STACK_DEPTH),
      .CALL_STACK_DEPTH (CALL_STACK_DEPTH),
      .MEMORY_WORDS     (MEMORY_WORDS),
      .REGISTER_COUNT   (REGISTER_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {4'b0000, rsp};

endmodule

// ===== rtl/smeu_ram.sv =====
module smeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/smeu_front.sv =====
module smeu_front
   import smeu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic        clearing,
   input  logic        pop,
   output logic        head_valid,
   output inst_type    head
);

   inst_type   q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   inst_type   incoming;
   logic       push;

   always_comb begin
      incoming.op          = req_tdata[4:0];
      incoming.use_const   = req_tdata[5];
      incoming.use_reg     = req_tdata[6];
      incoming.use_mem     = req_tdata[7];
      incoming.const_value = req_tdata[39:8];
      incoming.reg_select  = req_tdata[41:40];
      incoming.in_value    = req_tdata[73:42];
      // operand instructions may fault on a bad memory address
      incoming.needs_operand = (req_tdata[4:0] <= OP_JNE) || (req_tdata[4:0] == OP_CALL);
   end

   assign req_tready = (count_ff != 2'd2) && !clearing;
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != 2'd0);
   assign head       = q_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= incoming;
      end
   end

endmodule

// ===== rtl/smeu_back.sv =====
module smeu_back
   import smeu_pkg::*;
#(
   parameter int DATA_STACK_DEPTH = DATA_STACK_DEPTH_DEF,
   parameter int CALL_STACK_DEPTH = CALL_STACK_DEPTH_DEF,
   parameter int MEMORY_WORDS     = MEMORY_WORDS_DEF,
   parameter int REGISTER_COUNT   = REGISTER_COUNT_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  inst_type head,
   output logic     pop,
   output logic     clearing,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output rsp_type  rsp
);

   localparam int DW  = $clog2(DATA_STACK_DEPTH + 1);
   localparam int AW  = (DATA_STACK_DEPTH > 1) ? $clog2(DATA_STACK_DEPTH) : 1;
   localparam int CW  = $clog2(CALL_STACK_DEPTH + 1);
   localparam int CAW = (CALL_STACK_DEPTH > 1) ? $clog2(CALL_STACK_DEPTH) : 1;
   localparam int MA  = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
   localparam logic [MA-1:0] CLR_LAST = MA'(MEMORY_WORDS - 1);
   localparam logic [DW-1:0] DS_FULL  = DW'(DATA_STACK_DEPTH);
   localparam logic [CW-1:0] CS_FULL  = CW'(CALL_STACK_DEPTH);

   state_type state_ff, state_in;

   logic [31:0]   regs_ff [REGISTER_COUNT];
   logic [DW-1:0] dep_ff, dep_nx_ff;
   logic [CW-1:0] cd_ff, cd_nx_ff;
   logic [15:0]   pc_ff;
   logic [MA-1:0] clr_ff;

   inst_type      inst_ff;
   logic [31:0]   rv_ff, addr_ff, a_ff;
   logic          reg_ok_ff;

   // plan computed in the execute cycle, committed when the result leaves
   logic [2:0]    st_ff;
   logic [15:0]   nip_ff;
   logic          ov_ff;
   logic [31:0]   oval_ff;
   logic          ds_we_ff, dm_we_ff, rg_we_ff, cs_we_ff;
   logic [AW-1:0] ds_wa_ff;
   logic [31:0]   ds_wd_ff;
   logic          div_ff, sqrt_ff;

   // iterative divide and root
   logic [31:0]   rem_ff, quo_ff, mb_ff;
   logic          neg_ff;
   logic [31:0]   x_ff, r_ff, bit_ff;
   logic [4:0]    cnt_ff;

   logic          fire;
   logic [31:0]   ds_rdata, dm_rdata;
   logic [15:0]   cs_rdata;
   logic [AW-1:0] ds_ra;
   logic [DW-1:0] dep_m1, dep_m2;
   logic [CW-1:0] cd_m1;
   logic          dm_we;
   logic [MA-1:0] dm_wa;
   logic [31:0]   dm_wd, ds_wd;

   // head decode for register read and address
   logic [31:0]   h_rv, h_addr;
   logic          h_reg_ok;

   always_comb begin
      h_rv = 32'd0;
      for (int i = 0; i < REGISTER_COUNT; i++) begin
         if (int'(head.reg_select) == i) begin
            h_rv = regs_ff[i];
         end
      end
      h_reg_ok = int'(head.reg_select) < REGISTER_COUNT;
      h_addr = (head.use_const ? head.const_value : 32'd0) + (head.use_reg ? h_rv : 32'd0);
   end

   assign dep_m1 = dep_ff - DW'(1);
   assign dep_m2 = dep_ff - DW'(2);
   assign cd_m1  = cd_ff - CW'(1);

   // execute decision
   logic [31:0]   b_val, opval;
   logic          addr_ok, cond;
   logic [15:0]   pc1, pc2;
   logic [2:0]    ex_st;
   logic [15:0]   ex_nip;
   logic          ex_ov, ex_dswe, ex_dmwe, ex_rgwe, ex_cswe, ex_div, ex_sqrt;
   logic [31:0]   ex_oval, ex_dswd;
   logic [AW-1:0] ex_dswa;
   logic [DW-1:0] ex_dep;
   logic [CW-1:0] ex_cd;

   always_comb begin
      b_val   = ds_rdata;
      addr_ok = addr_ff < 32'(MEMORY_WORDS);
      opval   = (inst_ff.use_mem && addr_ok) ? dm_rdata :
                (inst_ff.use_reg ? rv_ff : inst_ff.const_value);
      pc1     = pc_ff + 16'd1;
      pc2     = pc_ff + 16'd2;
      cond    = 1'b0;
      ex_st   = ST_OK;
      ex_nip  = pc1;
      ex_ov   = 1'b0;
      ex_oval = 32'd0;
      ex_dswe = 1'b0;
      ex_dswa = dep_m1[AW-1:0];
      ex_dswd = 32'd0;
      ex_dmwe = 1'b0;
      ex_rgwe = 1'b0;
      ex_cswe = 1'b0;
      ex_div  = 1'b0;
      ex_sqrt = 1'b0;
      ex_dep  = dep_ff;
      ex_cd   = cd_ff;
      if (inst_ff.needs_operand && inst_ff.use_mem && !addr_ok) begin
         ex_st = ST_BADADDR;
      end else begin
         unique case (inst_ff.op) inside
            OP_PUSH, OP_IN: begin
               if (dep_ff == DS_FULL) begin
                  ex_st = ST_STACK;
               end else begin
                  ex_dswe = 1'b1;
                  ex_dswa = dep_ff[AW-1:0];
                  ex_dswd = (inst_ff.op == OP_PUSH) ? opval : inst_ff.in_value;
                  ex_dep  = dep_ff + DW'(1);
                  ex_nip  = (inst_ff.op == OP_PUSH) ? pc2 : pc1;
               end
            end
            OP_POP: begin
               if (dep_ff == '0) begin
                  ex_st = ST_STACK;
               end else begin
                  ex_dep  = dep_m1;
                  ex_dmwe = inst_ff.use_mem;
                  ex_rgwe = !inst_ff.use_mem && inst_ff.use_reg && reg_ok_ff;
                  ex_nip  = pc2;
               end
            end
            OP_JMP: ex_nip = opval[15:0];
            [OP_JB:OP_JNE]: begin
               if (dep_ff < DW'(2)) begin
                  ex_st = ST_STACK;
               end else begin
                  case (inst_ff.op)
                     OP_JB:   cond = $signed(b_val) < $signed(a_ff);
                     OP_JBE:  cond = !($signed(a_ff) < $signed(b_val));
                     OP_JA:   cond = $signed(a_ff) < $signed(b_val);
                     OP_JAE:  cond = !($signed(b_val) < $signed(a_ff));
                     OP_JE:   cond = a_ff == b_val;
                     default: cond = a_ff != b_val;
                  endcase
                  ex_nip = cond ? opval[15:0] : pc2;
               end
            end
            [OP_ADD:OP_DIV]: begin
               if (dep_ff < DW'(2)) begin
                  ex_st = ST_STACK;
               end else if (inst_ff.op == OP_DIV && b_val == 32'd0) begin
                  ex_st = ST_DIVZERO;
               end else begin
                  ex_dswe = 1'b1;
                  ex_dswa = dep_m2[AW-1:0];
                  ex_dep  = dep_m1;
                  ex_div  = inst_ff.op == OP_DIV;
                  case (inst_ff.op)
                     OP_ADD:  ex_dswd = a_ff + b_val;
                     OP_SUB:  ex_dswd = a_ff - b_val;
                     OP_MUL:  ex_dswd = a_ff * b_val;
                     default: ex_dswd = 32'd0;
                  endcase
               end
            end
            OP_OUT: begin
               if (dep_ff == '0) begin
                  ex_st = ST_STACK;
               end else begin
                  ex_dep  = dep_m1;
                  ex_ov   = 1'b1;
                  ex_oval = a_ff;
               end
            end
            OP_HALT: ex_st = ST_HALTED;
            OP_CALL: begin
               if (cd_ff == CS_FULL) begin
                  ex_st = ST_STACK;
               end else begin
                  ex_cswe = 1'b1;
                  ex_cd   = cd_ff + CW'(1);
                  ex_nip  = opval[15:0];
               end
            end
            OP_RET: begin
               if (cd_ff == '0) begin
                  ex_st = ST_STACK;
               end else begin
                  ex_cd  = cd_m1;
                  ex_nip = cs_rdata;
               end
            end
            OP_SQRT: begin
               if (dep_ff == '0) begin
                  ex_st = ST_STACK;
               end else if (a_ff[31]) begin
                  ex_st = ST_NEGROOT;
               end else begin
                  ex_dswe = 1'b1;
                  ex_sqrt = 1'b1;
               end
            end
            default: ex_st = ST_UNKNOWN;
         endcase
      end
      if (ex_st != ST_OK) begin
         ex_nip  = pc_ff;
         ex_ov   = 1'b0;
         ex_oval = 32'd0;
         ex_dswe = 1'b0;
         ex_dmwe = 1'b0;
         ex_rgwe = 1'b0;
         ex_cswe = 1'b0;
         ex_div  = 1'b0;
         ex_sqrt = 1'b0;
         ex_dep  = dep_ff;
         ex_cd   = cd_ff;
      end
   end

   // iteration steps
   logic [32:0] div_sh;
   logic [31:0] sq_t, root_rnd, quo_sgn;

   always_comb begin
      div_sh   = {rem_ff, quo_ff[31]};
      sq_t     = r_ff + bit_ff;
      root_rnd = (x_ff > r_ff) ? r_ff + 32'd1 : r_ff;
      quo_sgn  = neg_ff ? 32'd0 - quo_ff : quo_ff;
   end

   assign fire = (state_ff == S_FIN) && (!rsp_tvalid || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == CLR_LAST) state_in = S_IDLE;
         S_IDLE:  if (head_valid) state_in = S_RDA;
         S_RDA:   state_in = S_RDB;
         S_RDB:   state_in = S_EXEC;
         S_EXEC:  state_in = ex_div ? S_DIV : (ex_sqrt ? S_SQRT : S_FIN);
         S_DIV:   if (cnt_ff == 5'd31) state_in = S_FIN;
         S_SQRT:  if (cnt_ff == 5'd15) state_in = S_FIN;
         S_FIN:   if (fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop      = 1'b0;
      clearing = 1'b0;
      ds_ra    = dep_m2[AW-1:0];
      unique case (state_ff)
         S_CLEAR: clearing = 1'b1;
         S_IDLE:  pop = head_valid;
         S_RDA:   ds_ra = dep_m1[AW-1:0];
         default: ;
      endcase
   end

   always_comb begin
      dm_we = clearing || (fire && dm_we_ff);
      dm_wa = clearing ? clr_ff : addr_ff[MA-1:0];
      dm_wd = clearing ? 32'd0 : a_ff;
      ds_wd = div_ff ? quo_sgn : (sqrt_ff ? root_rnd : ds_wd_ff);
   end

   smeu_ram #(.WIDTH(32), .DEPTH(DATA_STACK_DEPTH)) u_data_stack (
      .clock   (clock),
      .wr_en   (fire && ds_we_ff),
      .wr_addr (ds_wa_ff),
      .wr_data (ds_wd),
      .rd_addr (ds_ra),
      .rd_data (ds_rdata)
   );

   smeu_ram #(.WIDTH(32), .DEPTH(MEMORY_WORDS)) u_data_mem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_wa),
      .wr_data (dm_wd),
      .rd_addr (addr_ff[MA-1:0]),
      .rd_data (dm_rdata)
   );

   smeu_ram #(.WIDTH(16), .DEPTH(CALL_STACK_DEPTH)) u_call_stack (
      .clock   (clock),
      .wr_en   (fire && cs_we_ff),
      .wr_addr (cd_ff[CAW-1:0]),
      .wr_data (pc_ff + 16'd2),
      .rd_addr (cd_m1[CAW-1:0]),
      .rd_data (cs_rdata)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         dep_ff     <= '0;
         cd_ff      <= '0;
         pc_ff      <= 16'd0;
         rsp_tvalid <= 1'b0;
         for (int i = 0; i < REGISTER_COUNT; i++) begin
            regs_ff[i] <= 32'd0;
         end
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clr_ff <= clr_ff + MA'(1);
         end
         if (fire) begin
            dep_ff     <= dep_nx_ff;
            cd_ff      <= cd_nx_ff;
            pc_ff      <= nip_ff;
            rsp_tvalid <= 1'b1;
            for (int i = 0; i < REGISTER_COUNT; i++) begin
               if (rg_we_ff && int'(inst_ff.reg_select) == i) begin
                  regs_ff[i] <= a_ff;
               end
            end
         end else if (rsp_tready) begin
            rsp_tvalid <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && head_valid) begin
         inst_ff   <= head;
         rv_ff     <= h_rv;
         addr_ff   <= h_addr;
         reg_ok_ff <= h_reg_ok;
      end
      if (state_ff == S_RDB) begin
         a_ff <= ds_rdata;
      end
      if (state_ff == S_EXEC) begin
         st_ff     <= ex_st;
         nip_ff    <= ex_nip;
         ov_ff     <= ex_ov;
         oval_ff   <= ex_oval;
         ds_we_ff  <= ex_dswe;
         ds_wa_ff  <= ex_dswa;
         ds_wd_ff  <= ex_dswd;
         dm_we_ff  <= ex_dmwe;
         rg_we_ff  <= ex_rgwe;
         cs_we_ff  <= ex_cswe;
         dep_nx_ff <= ex_dep;
         cd_nx_ff  <= ex_cd;
         div_ff    <= ex_div;
         sqrt_ff   <= ex_sqrt;
         cnt_ff    <= 5'd0;
         rem_ff    <= 32'd0;
         quo_ff    <= a_ff[31] ? 32'd0 - a_ff : a_ff;
         mb_ff     <= b_val[31] ? 32'd0 - b_val : b_val;
         neg_ff    <= a_ff[31] ^ b_val[31];
         x_ff      <= a_ff;
         r_ff      <= 32'd0;
         bit_ff    <= 32'h4000_0000;
      end
      if (state_ff == S_DIV) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (div_sh >= {1'b0, mb_ff}) begin
            rem_ff <= 32'(div_sh - {1'b0, mb_ff});
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= div_sh[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (state_ff == S_SQRT) begin
         cnt_ff <= cnt_ff + 5'd1;
         bit_ff <= bit_ff >> 2;
         if (x_ff >= sq_t) begin
            x_ff <= x_ff - sq_t;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
      end
      if (fire) begin
         rsp.status    <= st_ff;
         rsp.out_value <= oval_ff;
         rsp.out_valid <= ov_ff;
         rsp.next_ip   <= nip_ff;
      end
   end

endmodule

// ===== rtl/smeu_checker.sv =====
module smeu_checker
   import smeu_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // right after reset nothing is taken or shown, as the memory sweep begins
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

   // an out value only comes with a clean status
   a_out_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[51:49] == ST_OK)
      else $error("out value with error status");

   // no out value means a zero value field
   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[16] |-> rsp_tdata[48:17] == 32'd0)
      else $error("stray out value");

endmodule

bind stack_machine_execute_unit smeu_checker u_checker (.*);
